>>> hdl/ipprd_pkg.sv
// ipprd_pkg: shared types and constants for the IPP request deframer.
// Holds the parser phase and attribute step codes, the result record and the markers.
// No dependencies.
package ipprd_pkg;

	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_OPEN  = 2'd1;
	localparam logic [1:0] CMD_CLOSE = 2'd2;

	localparam logic [7:0]  CHAR_CR       = 8'h0D;
	localparam logic [7:0]  CHAR_LF       = 8'h0A;
	localparam logic [31:0] HDR_END_MARK  = {CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
	localparam logic [7:0]  TAG_END       = 8'h03;
	localparam logic [7:0]  TAG_VALUE_MIN = 8'h10;
	localparam logic [15:0] OP_PRINT_JOB  = 16'h0001;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_HEADER = 3'd1,
		PH_ATTR   = 3'd2,
		PH_DOC    = 3'd3,
		PH_IGNORE = 3'd4,
		PH_CLOSED = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		AS_TAG     = 3'd0,
		AS_NLEN_HI = 3'd1,
		AS_NLEN_LO = 3'd2,
		AS_NAME    = 3'd3,
		AS_VLEN_HI = 3'd4,
		AS_VLEN_LO = 3'd5,
		AS_VALUE   = 3'd6
	} attr_step_t;

	typedef enum logic [1:0] {
		KIND_HEADER       = 2'd0,
		KIND_DOC_BYTE     = 2'd1,
		KIND_JOB_DONE     = 2'd2,
		KIND_CLOSED_EARLY = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] header;
		logic        accepted;
		logic [7:0]  out_byte;
		logic [31:0] document_length;
		logic [31:0] jobs_completed;
	} result_t;

endpackage

>>> hdl/ipprd_parser.sv
// ipprd_parser: parser state and its one-item update for the IPP request deframer.
// Computes next state and the optional result for the item in the input register.
// Depends on ipprd_pkg.
module ipprd_parser
	import ipprd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        printer_ready,
	output logic        res_valid,
	output result_t     res
);

	phase_t      phase_q,   phase_d;
	attr_step_t  astep_q,   astep_d;
	logic [31:0] window_q,  window_d;
	logic [2:0]  hpos_q,    hpos_d;
	logic [63:0] hdr_q,     hdr_d;
	logic [7:0]  lenhi_q,   lenhi_d;
	logic [15:0] skip_q,    skip_d;
	logic [31:0] doccnt_q,  doccnt_d;
	logic [31:0] jobs_q,    jobs_d;

	logic [15:0] len_w;
	logic [15:0] skip_dec;
	logic        print_ok;

	assign len_w    = {lenhi_q, data_byte};
	assign skip_dec = skip_q - 16'd1;
	assign print_ok = (hdr_d[47:32] == OP_PRINT_JOB) && printer_ready;

	// next state
	always_comb begin
		phase_d  = phase_q;
		astep_d  = astep_q;
		window_d = window_q;
		hpos_d   = hpos_q;
		hdr_d    = hdr_q;
		lenhi_d  = lenhi_q;
		skip_d   = skip_q;
		doccnt_d = doccnt_q;
		jobs_d   = jobs_q;
		case (command)
			CMD_OPEN: begin
				phase_d  = PH_SEARCH;
				astep_d  = AS_TAG;
				window_d = '0;
				hpos_d   = '0;
				hdr_d    = '0;
				lenhi_d  = '0;
				skip_d   = '0;
				doccnt_d = '0;
			end
			CMD_CLOSE: begin
				if (phase_q == PH_DOC && doccnt_q != '0 && jobs_q != '1) begin
					jobs_d = jobs_q + 32'd1;
				end
				phase_d = PH_CLOSED;
			end
			CMD_BYTE: begin
				case (phase_q)
					PH_SEARCH: begin
						window_d = {window_q[23:0], data_byte};
						if ({window_q[23:0], data_byte} == HDR_END_MARK) begin
							phase_d = PH_HEADER;
							hpos_d  = '0;
							hdr_d   = '0;
						end
					end
					PH_HEADER: begin
						hdr_d  = {hdr_q[55:0], data_byte};
						hpos_d = hpos_q + 3'd1;
						if (hpos_d == '0) begin
							if (print_ok) begin
								phase_d = PH_ATTR;
								astep_d = AS_TAG;
								skip_d  = '0;
								lenhi_d = '0;
							end else begin
								phase_d = PH_IGNORE;
							end
						end
					end
					PH_ATTR: begin
						case (astep_q)
							AS_TAG: begin
								if (data_byte == TAG_END) begin
									phase_d  = PH_DOC;
									doccnt_d = '0;
								end else if (data_byte >= TAG_VALUE_MIN) begin
									astep_d = AS_NLEN_HI;
								end
							end
							AS_NLEN_HI: begin
								lenhi_d = data_byte;
								astep_d = AS_NLEN_LO;
							end
							AS_VLEN_HI: begin
								lenhi_d = data_byte;
								astep_d = AS_VLEN_LO;
							end
							AS_NLEN_LO: begin
								if (len_w == '0) begin
									astep_d = AS_VLEN_HI;
								end else begin
									skip_d  = len_w;
									astep_d = AS_NAME;
								end
							end
							AS_VLEN_LO: begin
								if (len_w == '0) begin
									astep_d = AS_TAG;
								end else begin
									skip_d  = len_w;
									astep_d = AS_VALUE;
								end
							end
							AS_NAME: begin
								skip_d = skip_dec;
								if (skip_dec == '0) begin
									astep_d = AS_VLEN_HI;
								end
							end
							AS_VALUE: begin
								skip_d = skip_dec;
								if (skip_dec == '0) begin
									astep_d = AS_TAG;
								end
							end
							default: begin
							end
						endcase
					end
					PH_DOC: begin
						if (doccnt_q != '1) begin
							doccnt_d = doccnt_q + 32'd1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// result for this item
	always_comb begin
		res_valid           = 1'b0;
		res.kind            = KIND_HEADER;
		res.header          = hdr_d;
		res.accepted        = 1'b1;
		res.out_byte        = '0;
		res.document_length = '0;
		res.jobs_completed  = jobs_d;
		case (command)
			CMD_CLOSE: begin
				if (phase_q == PH_DOC) begin
					res_valid           = 1'b1;
					res.kind            = KIND_JOB_DONE;
					res.document_length = doccnt_q;
				end else if (phase_q == PH_ATTR) begin
					res_valid = 1'b1;
					res.kind  = KIND_CLOSED_EARLY;
				end
			end
			CMD_BYTE: begin
				if (phase_q == PH_HEADER && hpos_d == '0) begin
					res_valid    = 1'b1;
					res.kind     = KIND_HEADER;
					res.accepted = print_ok;
				end else if (phase_q == PH_DOC) begin
					res_valid    = 1'b1;
					res.kind     = KIND_DOC_BYTE;
					res.out_byte = data_byte;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			astep_q  <= AS_TAG;
			window_q <= '0;
			hpos_q   <= '0;
			hdr_q    <= '0;
			lenhi_q  <= '0;
			skip_q   <= '0;
			doccnt_q <= '0;
			jobs_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			astep_q  <= astep_d;
			window_q <= window_d;
			hpos_q   <= hpos_d;
			hdr_q    <= hdr_d;
			lenhi_q  <= lenhi_d;
			skip_q   <= skip_d;
			doccnt_q <= doccnt_d;
			jobs_q   <= jobs_d;
		end
	end

endmodule

>>> hdl/ipprd_out_reg.sv
// ipprd_out_reg: result register of the IPP request deframer.
// Holds one result item until the receiver takes it.
// Depends on ipprd_pkg.
module ipprd_out_reg
	import ipprd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_d,
	input  logic    out_stall,
	output logic    out_valid,
	output result_t res_q
);

	logic valid_q;

	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

endmodule

>>> hdl/ipp_request_deframer.sv
// ipp_request_deframer: top level of the IPP-over-HTTP request deframer.
// Instantiates ipprd_parser and ipprd_out_reg; depends on ipprd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per connection
//   event: a received byte, a connection open or a connection close.
//   After an open, bytes are dropped until CR LF CR LF; the next 8 bytes
//   form the IPP header and give one header item (kind 0). An accepted
//   Print-Job then has its attribute list skipped, and every byte after
//   the end tag leaves as a document byte item (kind 1). A close after the
//   end tag gives a job-finished item (kind 2), a close in the attribute
//   list a closed-early item (kind 3), and any other close no item.
//   Output channel (out_valid / out_stall) carries at most one result item per input item.
// Timing:
//   An item is held in the input register, where the parser state
//   is updated by single-pass logic, and its result is loaded into the
//   result register when the item advances; out_valid rises from that
//   register, and the receiver takes the result from it. One item per
//   cycle is sustained while no result waits on a stalled output; the
//   parser state update of one byte is the only loop.
// Reset and stall:
//   arst_n clears the parser to header search and the job counter to
//   zero. While out_stall holds a result, an item that makes no result
//   still advances; an item that makes a result waits in the input
//   register, and in_stall rises until the result register frees.
module ipp_request_deframer
	import ipprd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic        printer_ready,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  version_major,
	output logic [7:0]  version_minor,
	output logic [15:0] operation,
	output logic [31:0] request_number,
	output logic        accepted,
	output logic [7:0]  out_byte,
	output logic [31:0] document_length,
	output logic [31:0] jobs_completed
);

	logic       valid_s1;
	logic [1:0] command_s1;
	logic [7:0] data_byte_s1;
	logic       ready_s1;

	logic    advance;
	logic    res_valid;
	result_t res_d;
	result_t res_q;

	// Advance the held item when its result, if any, can enter the result register.
	assign advance  = valid_s1 && (!res_valid || !out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the item payload on acceptance only.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1   <= command;
			data_byte_s1 <= data_byte;
			ready_s1     <= printer_ready;
		end
	end

	ipprd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.command       (command_s1),
		.data_byte     (data_byte_s1),
		.printer_ready (ready_s1),
		.res_valid     (res_valid),
		.res           (res_d)
	);

	ipprd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res_valid),
		.res_d     (res_d),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Split the held result into the output ports.
	assign kind            = res_q.kind;
	assign version_major   = res_q.header[63:56];
	assign version_minor   = res_q.header[55:48];
	assign operation       = res_q.header[47:32];
	assign request_number  = res_q.header[31:0];
	assign accepted        = res_q.accepted;
	assign out_byte        = res_q.out_byte;
	assign document_length = res_q.document_length;
	assign jobs_completed  = res_q.jobs_completed;

endmodule
